// ----- rtl/wcfb_pkg.sv -----
package wcfb_pkg;

    localparam logic [7:0]  FRAME_SYNC  = 8'hFF;
    localparam logic [7:0]  FRAME_CMD   = 8'h07;
    localparam logic [7:0]  FRAME_PAD   = 8'h00;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;

    localparam logic [7:0]  DIR_FORWARD  = 8'b0101_0000;
    localparam logic [7:0]  DIR_BACKWARD = 8'b0000_0000;
    localparam logic [7:0]  DIR_LEFT     = 8'b0001_0000;
    localparam logic [7:0]  DIR_RIGHT    = 8'b0100_0000;
    localparam logic [7:0]  DIR_NONE     = 8'b0101_0000;

    localparam int unsigned IDX_W = 4;

    localparam logic [IDX_W-1:0] IDX_SYNC    = 4'd0;
    localparam logic [IDX_W-1:0] IDX_CMD     = 4'd1;
    localparam logic [IDX_W-1:0] IDX_LEFT    = 4'd2;
    localparam logic [IDX_W-1:0] IDX_PAD0    = 4'd3;
    localparam logic [IDX_W-1:0] IDX_RIGHT   = 4'd4;
    localparam logic [IDX_W-1:0] IDX_PAD1    = 4'd5;
    localparam logic [IDX_W-1:0] IDX_DIR     = 4'd6;
    localparam logic [IDX_W-1:0] IDX_CRC_LO  = 4'd7;
    localparam logic [IDX_W-1:0] IDX_CRC_HI  = 4'd8;

    typedef struct packed {
        logic              go_forward;
        logic              go_backward;
        logic              turn_left;
        logic              turn_right;
        logic signed [7:0] front_ir_count;
        logic signed [7:0] rear_ir_count;
    } t_in;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_out;

    typedef struct packed {
        logic [7:0] left_speed;
        logic [7:0] right_speed;
        logic [7:0] dir;
    } t_frame;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/wheel_command_frame_builder.sv -----
// Channel   Direction  Handshake                 Payload
// in        sink       i_in_valid / o_in_stall    wcfb_pkg::t_in
// out       source     o_out_valid / i_out_stall  wcfb_pkg::t_out
// cfg       sink       i_cfg_wr_en                i_cfg_wr_data (speed)
//
// Each request beat yields nine output beats, one per cycle unless the output stalls, from
// the single byte serializer. A request passes the hold and frame registers before output.
// The CRC advances one frame byte per unstalled cycle as bytes leave the serializer.
// Reset clears speed and all valid/state flags. Output stall holds the serializer;
// one request is buffered while a frame is in flight.
module wheel_command_frame_builder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  wcfb_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output wcfb_pkg::t_out o_out,
    input  logic           i_cfg_wr_en,
    input  logic [7:0]     i_cfg_wr_data
);
    import wcfb_pkg::*;

    logic [7:0]       r_speed;
    logic             r_hold_valid, n_hold_valid;
    t_frame           r_hold, n_hold;
    logic             r_active, n_active;
    logic [IDX_W-1:0] r_idx, n_idx;
    t_frame           r_frame, n_frame;
    logic [15:0]      r_crc, n_crc;
    logic             r_out_valid, n_out_valid;
    t_out             r_out, n_out;

    t_frame     in_frame;
    logic       drive;
    logic [7:0] half;
    logic       advance;
    logic       accept;
    logic [7:0] cur_byte;
    logic       frame_end;

    assign o_in_stall  = r_hold_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign accept  = i_in_valid && !r_hold_valid;
    assign advance = !r_out_valid || !i_out_stall;
    assign half    = {1'b0, r_speed[7:1]};
    assign drive   = (i_in.go_forward  && (i_in.front_ir_count > 8'sd0)) ||
                     (i_in.go_backward && (i_in.rear_ir_count  > 8'sd0));

    always_comb begin
        priority if (drive && i_in.turn_right) begin
            in_frame.left_speed  = r_speed;
            in_frame.right_speed = half;
        end else if (drive && i_in.turn_left) begin
            in_frame.left_speed  = half;
            in_frame.right_speed = r_speed;
        end else if (drive || i_in.turn_left || i_in.turn_right) begin
            in_frame.left_speed  = r_speed;
            in_frame.right_speed = r_speed;
        end else begin
            in_frame.left_speed  = 8'h00;
            in_frame.right_speed = 8'h00;
        end
        priority if (i_in.go_forward) begin
            in_frame.dir = DIR_FORWARD;
        end else if (i_in.go_backward) begin
            in_frame.dir = DIR_BACKWARD;
        end else if (i_in.turn_left) begin
            in_frame.dir = DIR_LEFT;
        end else if (i_in.turn_right) begin
            in_frame.dir = DIR_RIGHT;
        end else begin
            in_frame.dir = DIR_NONE;
        end
    end

    always_comb begin
        unique case (r_idx)
            IDX_SYNC:   cur_byte = FRAME_SYNC;
            IDX_CMD:    cur_byte = FRAME_CMD;
            IDX_LEFT:   cur_byte = r_frame.left_speed;
            IDX_PAD0:   cur_byte = FRAME_PAD;
            IDX_RIGHT:  cur_byte = r_frame.right_speed;
            IDX_PAD1:   cur_byte = FRAME_PAD;
            IDX_DIR:    cur_byte = r_frame.dir;
            IDX_CRC_LO: cur_byte = r_crc[7:0];
            IDX_CRC_HI: cur_byte = r_crc[15:8];
            default:    cur_byte = FRAME_PAD;
        endcase
    end

    assign frame_end = (r_idx == IDX_CRC_HI);

    always_comb begin
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        n_active     = r_active;
        n_idx        = r_idx;
        n_frame      = r_frame;
        n_crc        = r_crc;
        n_out_valid  = r_out_valid;
        n_out        = r_out;

        if (advance) begin
            n_out_valid = r_active;
            n_out.frame_byte = cur_byte;
            n_out.last_byte  = frame_end;
            if (r_active) begin
                n_idx = r_idx + 4'd1;
                if (r_idx == IDX_SYNC) begin
                    n_crc = CRC_INIT;
                end else if (r_idx != IDX_CRC_LO && r_idx != IDX_CRC_HI) begin
                    n_crc = crc_byte(r_crc, cur_byte);
                end
            end
            if (!r_active || frame_end) begin
                n_active = r_hold_valid;
                n_idx    = IDX_SYNC;
                n_frame  = r_hold;
                if (r_hold_valid) begin
                    n_hold_valid = 1'b0;
                end
            end
        end

        if (accept) begin
            n_hold_valid = 1'b1;
            n_hold       = in_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed      <= 8'h00;
            r_hold_valid <= 1'b0;
            r_active     <= 1'b0;
            r_idx        <= IDX_SYNC;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_speed <= i_cfg_wr_data;
            end
            r_hold_valid <= n_hold_valid;
            r_active     <= n_active;
            r_idx        <= n_idx;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold  <= n_hold;
        r_frame <= n_frame;
        r_crc   <= n_crc;
        r_out   <= n_out;
    end

endmodule
